[hw/rtl/assert_macros.svh]
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, off during reset.
`define AEAS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion, also checked during reset.
`define AEAS_ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[hw/rtl/aeas_pkg.sv]
// Package: types and constants of the epoch activity summarizer.
`default_nettype none
package aeas_pkg;

    localparam logic [2:0] ACT_SAMPLE = 3'd0;
    localparam logic [2:0] ACT_TIME   = 3'd1;
    localparam logic [2:0] ACT_EVENT  = 3'd2;
    localparam logic [2:0] ACT_PROMPT = 3'd3;
    localparam logic [2:0] ACT_STEPS  = 3'd4;

    localparam logic [7:0]  EPOCH_SEC_RESET = 8'd60;
    localparam logic [15:0] MEAN_CLIP       = 16'hfffe;
    localparam logic [15:0] MEAN_NONE       = 16'hffff;
    localparam logic [15:0] COUNT_MAX       = 16'hffff;
    localparam logic [9:0]  STEP_MAX        = 10'd1023;
    localparam logic [2:0]  PROMPT_MAX      = 3'd7;

    typedef struct packed {
        logic [2:0]         action;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic [31:0]        time_seconds;
        logic [15:0]        event_bits;
        logic               prompt_muted;
        logic [15:0]        step_increment;
    } t_in_item;

    typedef struct packed {
        logic [15:0] epoch_events;
        logic [2:0]  prompt_total;
        logic [2:0]  muted_prompt_total;
        logic [9:0]  step_total;
        logic [15:0] mean_magnitude;
        logic [31:0] epoch_start;
    } t_out_item;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } t_div_rsp;

endpackage
`default_nettype wire

[hw/rtl/aeas_in_if.sv]
// Input channel: valid/ready with one input word.
`default_nettype none
interface aeas_in_if import aeas_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/aeas_out_if.sv]
// Output channel: valid/ready with one result word.
`default_nettype none
interface aeas_out_if import aeas_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[hw/rtl/accel_epoch_activity_summarizer.sv]
// Top level: accelerometer epoch activity summarizer.
// Event, prompt and step words: handled in the idle state, ready again the next cycle.
// Sample word: three squares on one multiplier, 16 root steps, then the sum update.
// Time word: two passes of the shared divider; when it closes an epoch, a third pass
// computes the mean if there are enough samples, plus any result-slot stall.
// Synchronous active-low reset clears the epoch and sets epoch length to 60.
`default_nettype none
module accel_epoch_activity_summarizer import aeas_pkg::*; #(
    parameter int SAMPLE_RATE_HZ = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_data,
    aeas_in_if.sink     i_in,
    aeas_out_if.source  o_out
);

    localparam int PROD_W = $clog2(SAMPLE_RATE_HZ * 255 + 1);
    localparam int THR_W  = PROD_W - 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_SQRT,
        S_SUM,
        S_QS_GO,
        S_QS_WAIT,
        S_QN_GO,
        S_QN_WAIT,
        S_THR,
        S_MD_GO,
        S_MD_WAIT,
        S_EMIT
    } t_state;

    t_state      r_state;
    logic [7:0]  r_epoch_sec;

    logic [31:0] r_start_time;
    logic [31:0] r_sum;
    logic [15:0] r_count;
    logic [15:0] r_events;
    logic [9:0]  r_steps;
    logic [2:0]  r_prompts;
    logic [2:0]  r_muted;

    logic signed [15:0] r_ax;
    logic signed [15:0] r_ay;
    logic signed [15:0] r_az;
    logic [1:0]  r_idx;
    logic [31:0] r_prod;
    logic [31:0] r_ss;
    logic [3:0]  r_sq_step;
    logic [17:0] r_sq_rem;
    logic [15:0] r_root;

    logic [31:0] r_now;
    logic [31:0] r_q;
    logic [15:0] r_mean;

    logic        r_out_valid;
    t_out_item   r_out;

    t_div_req    div_req;
    t_div_rsp    div_rsp;

    logic [7:0]         len;
    logic [PROD_W-1:0]  rate_prod;
    logic [THR_W-1:0]   thr;
    logic signed [15:0] axis;
    logic signed [31:0] sq;
    logic [19:0]        sq_rem_t;
    logic [19:0]        sq_trial;
    logic               sq_ge;
    logic [16:0]        step_sum;
    logic               slot_free;

    always_comb begin
        len       = (r_epoch_sec == 8'd0) ? 8'd1 : r_epoch_sec;
        rate_prod = PROD_W'(SAMPLE_RATE_HZ) * PROD_W'(len);
        // half the expected samples per epoch
        thr       = rate_prod[PROD_W-1:1];
        case (r_idx)
            2'd0:    axis = r_ax;
            2'd1:    axis = r_ay;
            default: axis = r_az;
        endcase
        sq        = axis * axis;
        sq_rem_t  = {r_sq_rem, r_ss[31:30]};
        sq_trial  = {2'b00, r_root, 2'b01};
        sq_ge     = sq_rem_t >= sq_trial;
        step_sum  = 17'(r_steps) + 17'(i_in.data.step_increment);
        slot_free = !r_out_valid || o_out.ready;
    end

    always_comb begin
        div_req.start    = (r_state == S_QS_GO) || (r_state == S_QN_GO) ||
                           (r_state == S_MD_GO);
        div_req.divisor  = (r_state == S_MD_GO) ? r_count : 16'(len);
        case (r_state)
            S_QS_GO: div_req.dividend = r_start_time;
            S_QN_GO: div_req.dividend = r_now;
            default: div_req.dividend = r_sum;
        endcase
    end

    aeas_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_epoch_sec  <= EPOCH_SEC_RESET;
            r_start_time <= '0;
            r_sum        <= '0;
            r_count      <= '0;
            r_events     <= '0;
            r_steps      <= '0;
            r_prompts    <= '0;
            r_muted      <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_epoch_sec <= i_cfg_data;
            end
            if (o_out.valid && o_out.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        case (i_in.data.action)
                            ACT_SAMPLE: begin
                                r_ax    <= i_in.data.accel_x;
                                r_ay    <= i_in.data.accel_y;
                                r_az    <= i_in.data.accel_z;
                                r_idx   <= 2'd0;
                                r_ss    <= '0;
                                r_state <= S_MUL;
                            end
                            ACT_TIME: begin
                                r_now   <= i_in.data.time_seconds;
                                r_state <= S_QS_GO;
                            end
                            ACT_EVENT: begin
                                r_events <= r_events | i_in.data.event_bits;
                            end
                            ACT_PROMPT: begin
                                if (i_in.data.prompt_muted) begin
                                    if (r_muted != PROMPT_MAX) r_muted <= r_muted + 3'd1;
                                end else begin
                                    if (r_prompts != PROMPT_MAX) r_prompts <= r_prompts + 3'd1;
                                end
                            end
                            ACT_STEPS: begin
                                r_steps <= (step_sum > 17'(STEP_MAX)) ? STEP_MAX
                                                                      : step_sum[9:0];
                            end
                            default: ;
                        endcase
                    end
                end
                S_MUL: begin
                    r_prod  <= unsigned'(sq);
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    r_ss <= r_ss + r_prod;
                    if (r_idx == 2'd2) begin
                        r_sq_step <= '0;
                        r_sq_rem  <= '0;
                        r_root    <= '0;
                        r_state   <= S_SQRT;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_SQRT: begin
                    r_sq_rem  <= sq_ge ? 18'(sq_rem_t - sq_trial) : 18'(sq_rem_t);
                    r_root    <= {r_root[14:0], sq_ge};
                    r_ss      <= {r_ss[29:0], 2'b00};
                    r_sq_step <= r_sq_step + 4'd1;
                    if (r_sq_step == 4'd15) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_count != COUNT_MAX) begin
                        r_sum   <= r_sum + 32'(r_root);
                        r_count <= r_count + 16'd1;
                    end
                    r_state <= S_IDLE;
                end
                S_QS_GO: begin
                    r_state <= S_QS_WAIT;
                end
                S_QS_WAIT: begin
                    if (div_rsp.done) begin
                        r_q     <= div_rsp.quotient;
                        r_state <= S_QN_GO;
                    end
                end
                S_QN_GO: begin
                    r_state <= S_QN_WAIT;
                end
                S_QN_WAIT: begin
                    if (div_rsp.done) begin
                        r_state <= (div_rsp.quotient == r_q) ? S_IDLE : S_THR;
                    end
                end
                S_THR: begin
                    if (r_count != 16'd0 && r_count >= 16'(thr)) begin
                        r_state <= S_MD_GO;
                    end else begin
                        r_mean  <= MEAN_NONE;
                        r_state <= S_EMIT;
                    end
                end
                S_MD_GO: begin
                    r_state <= S_MD_WAIT;
                end
                S_MD_WAIT: begin
                    if (div_rsp.done) begin
                        r_mean  <= (div_rsp.quotient > 32'(MEAN_CLIP)) ? MEAN_CLIP
                                                                      : div_rsp.quotient[15:0];
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (slot_free) begin
                        r_out.epoch_events       <= r_events;
                        r_out.prompt_total       <= r_prompts;
                        r_out.muted_prompt_total <= r_muted;
                        r_out.step_total         <= r_steps;
                        r_out.mean_magnitude     <= r_mean;
                        r_out.epoch_start        <= r_start_time;
                        r_out_valid              <= 1'b1;
                        r_start_time             <= r_now;
                        r_sum                    <= '0;
                        r_count                  <= '0;
                        r_events                 <= '0;
                        r_steps                  <= '0;
                        r_prompts                <= '0;
                        r_muted                  <= '0;
                        r_state                  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

endmodule
`default_nettype wire

[hw/rtl/aeas_div.sv]
// Shared 32 by 16 bit restoring divider, one quotient bit per cycle.
`default_nettype none
module aeas_div import aeas_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [15:0] r_rem;
    logic [15:0] r_den;
    logic [31:0] r_num;

    logic [16:0] rem_sh;
    logic [16:0] rem_sub;
    logic        ge;

    always_comb begin
        rem_sh  = {r_rem, r_num[31]};
        ge      = rem_sh >= {1'b0, r_den};
        rem_sub = rem_sh - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_den  <= i_req.divisor;
                r_num  <= i_req.dividend;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[15:0] : rem_sh[15:0];
                r_num <= {r_num[30:0], ge};
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_num;

endmodule
`default_nettype wire

[hw/rtl/aeas_checker.sv]
// Port-level checker for the epoch activity summarizer, with its bind.
`default_nettype none
`include "assert_macros.svh"
module aeas_checker import aeas_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_valid,
    input logic      in_ready,
    input logic [2:0] in_action,
    input logic      out_valid,
    input logic      out_ready,
    input t_out_item out_data
);

    `AEAS_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result word dropped while stalled")
    `AEAS_ASSERT(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_data), "result word changed while stalled")
    `AEAS_ASSERT(a_long_busy, clk, rst_n, in_valid && in_ready && (in_action == ACT_SAMPLE || in_action == ACT_TIME) |=> !in_ready, "ready right after sample or time word")
    `AEAS_ASSERT(a_short_ready, clk, rst_n, in_valid && in_ready && (in_action == ACT_EVENT || in_action == ACT_PROMPT || in_action == ACT_STEPS) |=> in_ready, "not ready after single-cycle word")
    `AEAS_ASSERT_NR(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind accel_epoch_activity_summarizer aeas_checker u_aeas_checker (
    .clk       (i_clk),
    .rst_n     (i_rst_n),
    .in_valid  (i_in.valid),
    .in_ready  (i_in.ready),
    .in_action (i_in.data.action),
    .out_valid (o_out.valid),
    .out_ready (o_out.ready),
    .out_data  (o_out.data)
);
`default_nettype wire

[verif/epoch_record_checker.sv]
// Epoch record checker: predicts the closed-epoch records from the accepted input words and checks the block's output.
`timescale 1ns / 1ps
module epoch_record_checker import aeas_pkg::*; #(
    parameter int SAMPLE_RATE_HZ = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    aeas_in_if         i_in,
    aeas_out_if        i_out,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int unsigned MIN_FILL_PCT = 50;

    logic [7:0]  epoch_len;
    logic [31:0] start_time;
    logic [31:0] mag_sum;
    logic [15:0] n_samples;
    logic [15:0] events;
    logic [9:0]  steps;
    logic [2:0]  prompts;
    logic [2:0]  muted;
    t_out_item   records[$];
    int          fails = 0;

    function automatic void clear_epoch(input logic [31:0] t);
        start_time = t;
        mag_sum    = '0;
        n_samples  = '0;
        events     = '0;
        steps      = '0;
        prompts    = '0;
        muted      = '0;
    endfunction

    function automatic void field_check(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", field, want, got);
            fails++;
        end
    endfunction

    always @(posedge i_clk) begin : track
        t_out_item          rec;
        t_out_item          got;
        logic signed [31:0] ax, ay, az;
        logic [31:0]        ss, trial_sq, quot;
        logic [15:0]        root, trial;
        int unsigned        len, thr, step_sum;
        if (!i_rst_n) begin
            epoch_len = EPOCH_SEC_RESET;
            clear_epoch(32'd0);
            records.delete();
        end else begin
            if (i_cfg_we)
                epoch_len = i_cfg_data;
            if (i_in.valid && i_in.ready) begin
                len = (epoch_len == 8'd0) ? 1 : epoch_len;
                case (i_in.data.action)
                    ACT_SAMPLE: begin
                        // counter full: sample dropped, sum and count hold
                        if (n_samples != COUNT_MAX) begin
                            ax = i_in.data.accel_x;
                            ay = i_in.data.accel_y;
                            az = i_in.data.accel_z;
                            ss = ax * ax + ay * ay + az * az;
                            root = '0;
                            for (int b = 15; b >= 0; b--) begin
                                trial = root | (16'd1 << b);
                                trial_sq = trial * trial;
                                if (ss >= trial_sq)
                                    root = trial;
                            end
                            mag_sum = mag_sum + root;
                            n_samples = n_samples + 1'b1;
                        end
                    end
                    ACT_EVENT: begin
                        events = events | i_in.data.event_bits;
                    end
                    ACT_PROMPT: begin
                        if (i_in.data.prompt_muted) begin
                            if (muted != PROMPT_MAX)
                                muted = muted + 1'b1;
                        end else if (prompts != PROMPT_MAX) begin
                            prompts = prompts + 1'b1;
                        end
                    end
                    ACT_STEPS: begin
                        step_sum = steps + i_in.data.step_increment;
                        steps = (step_sum > STEP_MAX) ? STEP_MAX : 10'(step_sum);
                    end
                    ACT_TIME: begin
                        if (start_time / len != i_in.data.time_seconds / len) begin
                            thr = SAMPLE_RATE_HZ * len * MIN_FILL_PCT / 100;
                            if (n_samples != 0 && n_samples >= thr) begin
                                quot = mag_sum / n_samples;
                                rec.mean_magnitude = (quot > MEAN_CLIP) ? MEAN_CLIP : quot[15:0];
                            end else begin
                                rec.mean_magnitude = MEAN_NONE;
                            end
                            rec.epoch_events       = events;
                            rec.prompt_total       = prompts;
                            rec.muted_prompt_total = muted;
                            rec.step_total         = steps;
                            rec.epoch_start        = start_time;
                            records.push_back(rec);
                            clear_epoch(i_in.data.time_seconds);
                        end
                    end
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                got = i_out.data;
                if (records.size() == 0) begin
                    $error("record word with no closed epoch, epoch_start %0h", got.epoch_start);
                    fails++;
                end else begin
                    rec = records.pop_front();
                    field_check("epoch_events", rec.epoch_events, got.epoch_events);
                    field_check("prompt_total", rec.prompt_total, got.prompt_total);
                    field_check("muted_prompt_total", rec.muted_prompt_total,
                                got.muted_prompt_total);
                    field_check("step_total", rec.step_total, got.step_total);
                    field_check("mean_magnitude", rec.mean_magnitude, got.mean_magnitude);
                    field_check("epoch_start", rec.epoch_start, got.epoch_start);
                end
            end
        end
        o_pending    <= records.size();
        o_fail_count <= fails;
    end

endmodule

[verif/tb.sv]
// Testbench top: drives sample, event, prompt, step and time words through several epoch lengths.
`timescale 1ns / 1ps
module tb;
    import aeas_pkg::*;

    localparam int RATE_HZ       = 32;
    localparam int SETTLE_CYCLES = 150;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_data;
    int          fail_count;
    int          pending;

    bit          idle_on = 1'b1;
    logic [31:0] epoch_t = '0;
    int unsigned cur_len = EPOCH_SEC_RESET;
    int unsigned closes = 0;

    aeas_in_if  in_ch ();
    aeas_out_if out_ch ();

    accel_epoch_activity_summarizer #(
        .SAMPLE_RATE_HZ(RATE_HZ)
    ) dut (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_data(cfg_data),
        .i_in      (in_ch),
        .o_out     (out_ch)
    );

    epoch_record_checker #(
        .SAMPLE_RATE_HZ(RATE_HZ)
    ) record_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial begin
        #(64'd200_000_000);
        $display("tb: errors");
        $finish;
    end

    initial begin : record_sink
        int stall;
        out_ch.ready <= 1'b0;
        @(posedge clk);
        forever begin
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
            stall = idle_on ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    function automatic t_in_item noise_word(input logic [2:0] act);
        t_in_item w;
        w.action         = act;
        w.accel_x        = 16'($urandom);
        w.accel_y        = 16'($urandom);
        w.accel_z        = 16'($urandom);
        w.time_seconds   = $urandom;
        w.event_bits     = 16'($urandom);
        w.prompt_muted   = 1'($urandom);
        w.step_increment = 16'($urandom);
        return w;
    endfunction

    function automatic logic [15:0] accel_val();
        return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 9000) - 4500);
    endfunction

    task automatic put_word(input t_in_item w);
        int gap;
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        if (w.action == ACT_TIME && epoch_t / cur_len != w.time_seconds / cur_len) begin
            epoch_t = w.time_seconds;
            closes++;
        end
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        gap = idle_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic put_sample(input logic [15:0] x, input logic [15:0] y, input logic [15:0] z);
        t_in_item w;
        w = noise_word(ACT_SAMPLE);
        w.accel_x = x;
        w.accel_y = y;
        w.accel_z = z;
        put_word(w);
    endtask

    task automatic put_time(input logic [31:0] t);
        t_in_item w;
        w = noise_word(ACT_TIME);
        w.time_seconds = t;
        put_word(w);
    endtask

    task automatic put_events(input logic [15:0] bits);
        t_in_item w;
        w = noise_word(ACT_EVENT);
        w.event_bits = bits;
        put_word(w);
    endtask

    task automatic put_prompt(input logic is_muted);
        t_in_item w;
        w = noise_word(ACT_PROMPT);
        w.prompt_muted = is_muted;
        put_word(w);
    endtask

    task automatic put_steps(input logic [15:0] n);
        t_in_item w;
        w = noise_word(ACT_STEPS);
        w.step_increment = n;
        put_word(w);
    endtask

    // block may still be busy on a word that yields no record
    task automatic wait_idle();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_epoch_len(input logic [7:0] v);
        wait_idle();
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        cur_len = (v == 8'd0) ? 1 : v;
    endtask

    task automatic run_epochs(input logic [7:0] len_code, input int unsigned word_goal);
        int unsigned words, m, r, closes0;
        write_epoch_len(len_code);
        closes0 = closes;
        words = 0;
        while (words < word_goal || closes - closes0 < 4) begin
            idle_on = ($urandom_range(0, 3) != 0);
            m = $urandom_range(0, (cur_len * 24 < 72) ? cur_len * 24 : 72);
            repeat (m) begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    put_sample(accel_val(), accel_val(), accel_val());
                else if (r < 78)
                    put_events($urandom_range(0, 1) ? 16'($urandom)
                                                    : 16'd1 << $urandom_range(0, 15));
                else if (r < 86)
                    put_prompt(1'($urandom));
                else if (r < 94)
                    put_steps($urandom_range(0, 9) == 0 ? 16'($urandom)
                                                        : 16'($urandom_range(0, 200)));
                else
                    put_time((epoch_t / cur_len) * cur_len + $urandom_range(0, cur_len - 1));
            end
            if ($urandom_range(0, 9) == 0)
                put_word(noise_word(3'($urandom_range(0, 7))));
            if ($urandom_range(0, 9) == 0)
                put_time($urandom);
            else
                put_time((epoch_t / cur_len + 1 + $urandom_range(0, 1)) * cur_len
                         + $urandom_range(0, cur_len - 1));
            words += m + 1;
        end
        idle_on = 1'b1;
    endtask

    initial begin : stimulus
        logic [2:0] unk;
        rst_n       <= 1'b0;
        cfg_we      <= 1'b0;
        cfg_data    <= '0;
        in_ch.valid <= 1'b0;
        in_ch.data  <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset epoch length
        put_time(32'd59);
        put_sample(16'h8000, 16'h8000, 16'h8000);
        put_sample(16'h7fff, 16'h7fff, 16'h7fff);
        put_sample(16'h0000, 16'h0000, 16'h0000);
        put_sample(16'hffff, 16'h0001, 16'h8000);
        put_events(16'hffff);
        put_events(16'h0000);
        put_steps(16'hffff);
        put_steps(16'h0000);
        repeat (8) put_prompt(1'b0);
        repeat (8) put_prompt(1'b1);
        unk = ACT_STEPS;
        repeat (3) begin
            unk++;
            put_word(noise_word(unk));
        end
        put_time(32'd60);
        put_time(32'hffff_ffff);
        put_time(32'd0);

        // zero length reads as one second; enough samples for a computed mean
        write_epoch_len(8'd0);
        idle_on = 1'b0;
        put_time(epoch_t + 1);
        repeat (40) put_sample(16'($urandom), 16'($urandom), 16'($urandom));
        put_time(epoch_t + 1);
        idle_on = 1'b1;

        run_epochs(8'd1, 130);
        run_epochs(8'd2, 130);
        run_epochs(8'd255, 130);
        run_epochs(8'd3, 130);
        run_epochs(8'd0, 130);
        run_epochs(8'd4, 130);

        wait_idle();
        if (fail_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
